// ----- sv/rdc_pkg.sv -----
// shared types, constants and helpers for the radix digit converter
package rdc_pkg;

	localparam int unsigned RADIX_W     = 5;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned CHAR_W      = 7;
	localparam int unsigned DIV_STEP    = 8;
	localparam int unsigned OQ_DEPTH    = 4;
	localparam int unsigned OQ_AW       = 2;
	localparam int unsigned OQ_CW       = 3;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} back_state_t;

	typedef struct packed {
		logic vld;
		logic zero;
	} job_ctl_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              empty_res;
		logic              last;
	} res_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] e;
		e = r;
		if (r < RADIX_MIN) begin
			e = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			e = RADIX_MAX;
		end
		return e;
	endfunction

	// "0123456789ABCDEF"
	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] g;
		if (d < 4'd10) begin
			g = 7'd48 + {3'b000, d};
		end else begin
			g = 7'd55 + {3'b000, d};
		end
		return g;
	endfunction

endpackage

// ----- sv/rdc_ram.sv -----
// generic single-write, single-read ram with registered read data
module rdc_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/rdc_front.sv -----
// request intake: zero classification and a two-entry job queue
module rdc_front import rdc_pkg::*; #(
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	output job_ctl_t              job,
	output logic [VALUE_BITS-1:0] job_value,
	input  logic                  job_take
);

	logic [VALUE_BITS-1:0] val_q  [2];
	logic                  zero_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  wr_en;
	logic                  rd_en;

	assign full    = (cnt_q == 2'd2);
	assign wr_en   = push && !full;
	assign job.vld = (cnt_q != 2'd0);
	assign rd_en   = job_take && job.vld;

	assign job.zero  = zero_q[rd_ptr_q];
	assign job_value = val_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_q[wr_ptr_q]  <= value;
			zero_q[wr_ptr_q] <= (value == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ----- sv/rdc_back.sv -----
// digit generation by repeated division, msd-first readout and result queue
module rdc_back import rdc_pkg::*; #(
	parameter int unsigned VALUE_BITS  = 31,
	parameter int unsigned DIGIT_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [RADIX_W-1:0]    radix_eff,
	input  job_ctl_t              job,
	input  logic [VALUE_BITS-1:0] job_value,
	output logic                  job_take,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  empty_res,
	output logic                  last
);

	localparam int unsigned NPASS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int unsigned PW    = NPASS * DIV_STEP;
	localparam int unsigned PC_W  = (NPASS > 1) ? $clog2(NPASS) : 1;
	localparam int unsigned AW    = $clog2(DIGIT_SLOTS);
	localparam int unsigned CW    = $clog2(DIGIT_SLOTS + 1);

	back_state_t        state_q;
	logic [PW-1:0]      work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [PC_W-1:0]    pass_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_left_q;
	logic [CW-1:0]      rd_addr;
	logic               rd_vld_s1;
	logic               last_s1;

	logic [PW-1:0]      work_nxt;
	logic [RADIX_W-1:0] rem_nxt;

	logic               ram_we;
	logic               ram_re;
	logic [DIGIT_W-1:0] ram_rdata;

	res_t               oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]   oq_wr_q;
	logic [OQ_AW-1:0]   oq_rd_q;
	logic [OQ_CW-1:0]   oq_cnt_q;
	logic               oq_push;
	logic               oq_pop;
	logic               zero_push;
	res_t               oq_wdata;
	logic               last_pass;
	logic               div_done;

	// restoring division by the radix, DIV_STEP quotient bits a cycle
	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [PW-1:0]      w;
		r = {1'b0, rem_q};
		w = work_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[RADIX_W-2:0], w[PW-1]};
			w = {w[PW-2:0], 1'b0};
			if (r >= radix_eff) begin
				r    = r - radix_eff;
				w[0] = 1'b1;
			end
		end
		rem_nxt  = r;
		work_nxt = w;
	end

	assign last_pass = (pass_q == PC_W'(NPASS - 1));
	assign div_done  = (work_nxt == '0) || (cnt_q == CW'(DIGIT_SLOTS - 1));
	assign rd_addr   = rd_left_q - CW'(1);

	assign ram_we    = (state_q == ST_DIV) && last_pass;
	assign ram_re    = (state_q == ST_EMIT) &&
		((oq_cnt_q + OQ_CW'(rd_vld_s1)) < OQ_CW'(OQ_DEPTH));
	assign zero_push = (state_q == ST_IDLE) && job.vld && job.zero &&
		!rd_vld_s1 && (oq_cnt_q < OQ_CW'(OQ_DEPTH));
	assign job_take  = (state_q == ST_IDLE) && job.vld && (!job.zero || zero_push);

	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (DIGIT_SLOTS)
	) u_digit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_nxt[DIGIT_W-1:0]),
		.re    (ram_re),
		.raddr (rd_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (job_take && !job.zero) begin
			work_q <= PW'(job_value);
		end else if (state_q == ST_DIV) begin
			work_q <= work_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rem_q     <= '0;
			pass_q    <= '0;
			cnt_q     <= '0;
			rd_left_q <= '0;
			rd_vld_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				last_s1 <= (rd_left_q == CW'(1));
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_take && !job.zero) begin
						rem_q   <= '0;
						pass_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_pass) begin
						rem_q  <= '0;
						pass_q <= '0;
						cnt_q  <= cnt_q + CW'(1);
						if (div_done) begin
							rd_left_q <= cnt_q + CW'(1);
							state_q   <= ST_EMIT;
						end
					end else begin
						rem_q  <= rem_nxt[DIGIT_W-1:0];
						pass_q <= pass_q + PC_W'(1);
					end
				end
				ST_EMIT: begin
					if (ram_re) begin
						rd_left_q <= rd_addr;
						if (rd_left_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result queue
	assign oq_push = rd_vld_s1 || zero_push;
	assign oq_pop  = pop && !empty;
	assign empty   = (oq_cnt_q == '0);

	always_comb begin
		if (rd_vld_s1) begin
			oq_wdata.digit_char = digit_glyph(ram_rdata);
			oq_wdata.empty_res  = 1'b0;
			oq_wdata.last       = last_s1;
		end else begin
			oq_wdata.digit_char = '0;
			oq_wdata.empty_res  = 1'b1;
			oq_wdata.last       = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= oq_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
		end
	end

	assign digit_char = oq_q[oq_rd_q].digit_char;
	assign empty_res  = oq_q[oq_rd_q].empty_res;
	assign last       = oq_q[oq_rd_q].last;

endmodule

// ----- sv/radix_digit_converter_top.sv -----
// top level of the radix digit converter: radix register, intake and digit engine
//
//  channel   direction  handshake        payload
//  request   in         push / full      value
//  result    out        pop / empty      digit_char, empty_res, last
//  radix     in         cfg_we           cfg_wdata
//
//  a zero request is written to the result queue at the edge where the engine takes it
//  a nonzero request is divided by the radix once per digit (8 quotient
//  bits a cycle over the padded value), then its digits are read out from the digit ram
//  a two-entry request queue lets new requests in while the engine works
//  a four-entry result queue absorbs pop stalls; readout pauses while it is full
//  reset sets the radix to ten and empties both queues
module radix_digit_converter_top import rdc_pkg::*; #(
	parameter int unsigned VALUE_BITS  = 31,
	parameter int unsigned DIGIT_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  empty_res,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [RADIX_W-1:0]    cfg_wdata
);

	logic [RADIX_W-1:0]    radix_q;
	logic [RADIX_W-1:0]    radix_eff;
	job_ctl_t              job;
	logic [VALUE_BITS-1:0] job_value;
	logic                  job_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	assign radix_eff = clamp_radix(radix_q);

	rdc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.job       (job),
		.job_value (job_value),
		.job_take  (job_take)
	);

	rdc_back #(
		.VALUE_BITS  (VALUE_BITS),
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_eff  (radix_eff),
		.job        (job),
		.job_value  (job_value),
		.job_take   (job_take),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.empty_res  (empty_res),
		.last       (last)
	);

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the radix digit converter: directed, random and backpressure runs
`timescale 1ns / 1ps

module testbench;
	import rdc_pkg::*;

	localparam int unsigned VALUE_BITS  = 31;
	localparam int unsigned DIGIT_SLOTS = 32;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 200;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [VALUE_BITS-1:0] value     = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [CHAR_W-1:0]     digit_char;
	logic                  empty_res;
	logic                  last;
	logic                  cfg_we    = 1'b0;
	logic [RADIX_W-1:0]    cfg_wdata = '0;

	res_t               digits_due[$];
	logic [RADIX_W-1:0] radix_copy     = RADIX_RESET;
	string              glyph_set      = "0123456789ABCDEF";
	int                 mismatches     = 0;
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int unsigned        quiet_cycles   = 0;
	int unsigned        hold_left      = 0;
	bit                 hold_tog       = 1'b0;
	bit                 hold_seen      = 1'b0;

	radix_digit_converter_top #(
		.VALUE_BITS (VALUE_BITS),
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.digit_char(digit_char),
		.empty_res (empty_res),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_base(input logic [RADIX_W-1:0] r);
		if (r < 2) begin
			return 2;
		end
		if (r > 16) begin
			return 16;
		end
		return 32'(r);
	endfunction

	task automatic predict_digits(input logic [VALUE_BITS-1:0] v);
		int unsigned digs[DIGIT_SLOTS];
		int unsigned base;
		int unsigned q;
		int          n;
		byte         g;
		res_t        item;
		base = eff_base(radix_copy);
		q = 32'(v);
		n = 0;
		if (q == 0) begin
			item.digit_char = '0;
			item.empty_res = 1'b1;
			item.last = 1'b1;
			digits_due.push_back(item);
		end else begin
			while (q != 0 && n < DIGIT_SLOTS) begin
				digs[n] = q % base;
				q = q / base;
				n++;
			end
			for (int k = n - 1; k >= 0; k--) begin
				g = glyph_set[digs[k]];
				item.digit_char = g[CHAR_W-1:0];
				item.empty_res = 1'b0;
				item.last = (k == 0);
				digits_due.push_back(item);
			end
		end
	endtask

	function automatic logic [VALUE_BITS-1:0] random_value();
		int unsigned sel;
		int unsigned base;
		int unsigned p;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			return '0;
		end
		if (sel < 35) begin
			return VALUE_BITS'($urandom_range(1, 300));
		end
		if (sel < 50) begin
			base = eff_base(radix_copy);
			p = 1;
			repeat ($urandom_range(1, 31)) begin
				if (p <= 32'h7FFF_FFFF / base) begin
					p = p * base;
				end
			end
			return VALUE_BITS'(p - $urandom_range(0, 1));
		end
		return VALUE_BITS'($urandom());
	endfunction

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		predict_digits(v);
	endtask

	task automatic settle_idle();
		push <= 1'b0;
		while (digits_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] r);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_copy = r;
	endtask

	task automatic check_result();
		res_t want;
		if (digits_due.size() == 0) begin
			$display("%0t: unexpected result char %h empty %b last %b",
				$time, digit_char, empty_res, last);
			mismatches++;
		end else begin
			want = digits_due.pop_front();
			if (digit_char !== want.digit_char || empty_res !== want.empty_res
					|| last !== want.last) begin
				$display("%0t: expected char %h empty %b last %b, got char %h empty %b last %b",
					$time, want.digit_char, want.empty_res, want.last,
					digit_char, empty_res, last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			check_result();
		end
		if (hold_tog != hold_seen) begin
			hold_seen = hold_tog;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// reset radix first, then zero, one, max and digit boundaries
	task automatic test_edge_values();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_value('0);
		send_value(1);
		send_value(9);
		send_value(10);
		send_value({VALUE_BITS{1'b1}});
		set_radix(2);
		send_value('0);
		send_value(1);
		send_value({VALUE_BITS{1'b1}});
		send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
		set_radix(16);
		send_value(15);
		send_value(16);
		send_value({VALUE_BITS{1'b1}});
		set_radix(3);
		send_value({VALUE_BITS{1'b1}});
		set_radix(7);
		send_value(48);
	endtask

	// out-of-range radix values clamp to two or sixteen
	task automatic test_radix_limits();
		set_radix(0);
		send_value(5);
		set_radix(1);
		send_value(6);
		set_radix(17);
		send_value(255);
		set_radix(31);
		send_value(31'h000A_BCDE);
		send_value('0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		settle_idle();
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (2) begin
			set_radix(RADIX_W'($urandom_range(0, 31)));
			repeat (35) send_value(random_value());
		end
	endtask

	// long pop hold-off fills both queues, then drain fully before more requests
	task automatic test_backpressure();
		set_radix(2);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_tog = ~hold_tog;
		repeat (24) send_value({1'b1, (VALUE_BITS-1)'($urandom())});
		settle_idle();
		set_radix(RADIX_W'($urandom_range(2, 16)));
		repeat (6) send_value(random_value());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_values();
		test_radix_limits();
		test_random_traffic(0, 0);
		test_random_traffic(80, 0);
		test_random_traffic(0, 80);
		test_random_traffic(18, 18);
		test_backpressure();
		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && digits_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
